### rtl/core/bitmap_run_block_allocator_unit_macros.svh
// Assertion helpers for the checker file bmra_checker.sv.
`ifndef BITMAP_RUN_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_RUN_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BRBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define BRBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### rtl/core/bmra_pkg.sv
package bmra_pkg;

  localparam int SLICE_W   = 8;   // blocks held by one cell
  localparam int CNT_W     = 9;   // run length / count width
  localparam int OUT_IDX_W = 8;   // width of the index result field
  localparam int OP_W      = 1;
  localparam int START_W   = 8;
  localparam int USABLE_W  = 9;

  localparam logic [USABLE_W-1:0] USABLE_RESET = 9'd256;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [CNT_W-1:0] run;    // free blocks seen back to back so far
  } scan_tok_t;

endpackage

### rtl/core/bmra_cell.sv
module bmra_cell #(
  parameter int BASE  = 0,
  parameter int IDX_W = 8,
  parameter int EXT_W = 10,
  parameter int LIM_W = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bmra_pkg::scan_tok_t        tok_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [bmra_pkg::CNT_W-1:0] count_i,
  input  logic [LIM_W-1:0]           limit_i,
  input  logic                       wr_en_i,
  input  logic                       wr_val_i,
  input  logic [EXT_W-1:0]           wr_lo_i,
  input  logic [EXT_W-1:0]           wr_hi_i,
  output bmra_pkg::scan_tok_t        tok_o,
  output logic [IDX_W-1:0]           idx_o
);
  import bmra_pkg::*;

  logic [SLICE_W-1:0] used_r;
  scan_tok_t          tok_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SLICE_W-1:0] hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      tok_r     <= '0;
    end else begin
      tok_r <= tok_i;
      for (int j = 0; j < SLICE_W; j++) begin
        if (wr_en_i && hit[j]) used_r[j] <= wr_val_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_i;
  end

  // bits of this slice covered by the broadcast write range
  always_comb begin
    for (int j = 0; j < SLICE_W; j++) begin
      hit[j] = (EXT_W'(BASE + j) >= wr_lo_i) && (EXT_W'(BASE + j) < wr_hi_i);
    end
  end

  // extend the free run over this slice, stop at the usable limit
  always_comb begin
    logic             found;
    logic [CNT_W-1:0] run;
    logic [IDX_W-1:0] idx;
    found = tok_r.found;
    run   = tok_r.run;
    idx   = idx_r;
    for (int j = 0; j < SLICE_W; j++) begin
      if (!found && (EXT_W'(BASE + j) < EXT_W'(limit_i))) begin
        if (used_r[j]) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run == count_i) begin
            found = 1'b1;
            idx   = IDX_W'(EXT_W'(BASE + j + 1) - EXT_W'(count_i));
          end
        end
      end
    end
    tok_o.valid = tok_r.valid;
    tok_o.found = found;
    tok_o.run   = run;
    idx_o       = idx;
  end

endmodule

### rtl/core/bitmap_run_block_allocator_unit.sv
// First-fit allocator of contiguous block runs over a used/free bitmap.
// Command channel: an item (in_op, in_count, in_start_index) is taken when
// start is high and busy is low. Allocate (in_op 0) looks for the lowest run
// of in_count free blocks below the usable limit, marks it used and returns
// its start on out_index; free (in_op 1) clears in_count blocks from
// in_start_index. Each item gives exactly one result, shown for one cycle
// with out_valid; the receiver cannot stall, so results are never held.
// Config: cfg_usable_blocks is written on a cfg_valid/cfg_ready transfer;
// cfg_ready is always high. Write it only while the block is idle.
// Structure: the bitmap sits in a chain of ceil(POOL_BLOCKS/8) cells,
// 8 blocks each; a scan token walks one cell per cycle. A successful
// allocate scans, then marks its run; a failed scan answers as the token
// leaves the last cell; a valid free goes to marking at once; rejected or
// empty items answer from idle. One item is in work at a time (busy high).
// Reset clears the whole bitmap at once and sets the usable count to 256.
module bitmap_run_block_allocator_unit #(
  parameter int POOL_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bmra_pkg::OP_W-1:0]     in_op,
  input  logic [bmra_pkg::CNT_W-1:0]    in_count,
  input  logic [bmra_pkg::START_W-1:0]  in_start_index,
  output logic                          out_valid,
  output logic [bmra_pkg::OUT_IDX_W-1:0] out_index,
  output bmra_pkg::status_t             out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bmra_pkg::USABLE_W-1:0] cfg_usable_blocks
);
  import bmra_pkg::*;

  localparam int CELLS = (POOL_BLOCKS + SLICE_W - 1) / SLICE_W;
  localparam int IDX_W = $clog2(POOL_BLOCKS);
  localparam int LIM_W = $clog2(POOL_BLOCKS + 1);
  localparam int CMP_W = (LIM_W > USABLE_W) ? LIM_W : USABLE_W;
  localparam int EXT_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK
  } state_t;

  state_t                 state_r;
  logic [USABLE_W-1:0]    usable_r;
  logic [CNT_W-1:0]       count_r;
  logic [EXT_W-1:0]       wr_lo_r;
  logic [EXT_W-1:0]       wr_hi_r;
  logic                   wr_val_r;
  logic                   out_valid_r;
  logic [OUT_IDX_W-1:0]   out_index_r;
  status_t                out_status_r;

  logic [LIM_W-1:0]       limit;
  logic                   accept;
  logic                   alloc_ok;
  logic                   free_range_bad;
  logic                   scan_go;
  logic                   wr_en;

  scan_tok_t              tok   [0:CELLS];
  logic [IDX_W-1:0]       idx_c [0:CELLS];

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  assign limit = (CMP_W'(usable_r) > CMP_W'(POOL_BLOCKS)) ? LIM_W'(POOL_BLOCKS)
                                                          : LIM_W'(usable_r);

  assign alloc_ok       = (in_count != '0) && (CMP_W'(in_count) <= CMP_W'(limit));
  assign free_range_bad = ((CMP_W + 1)'(in_start_index) + (CMP_W + 1)'(in_count))
                          > (CMP_W + 1)'(limit);
  assign scan_go        = accept && (op_t'(in_op) == OP_ALLOC) && alloc_ok;
  assign wr_en          = (state_r == S_MARK);

  assign tok[0].valid = scan_go;
  assign tok[0].found = 1'b0;
  assign tok[0].run   = '0;
  assign idx_c[0]     = '0;

  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    bmra_cell #(
      .BASE  (c * SLICE_W),
      .IDX_W (IDX_W),
      .EXT_W (EXT_W),
      .LIM_W (LIM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_i    (tok[c]),
      .idx_i    (idx_c[c]),
      .count_i  (count_r),
      .limit_i  (limit),
      .wr_en_i  (wr_en),
      .wr_val_i (wr_val_r),
      .wr_lo_i  (wr_lo_r),
      .wr_hi_i  (wr_hi_r),
      .tok_o    (tok[c+1]),
      .idx_o    (idx_c[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      usable_r    <= USABLE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) usable_r <= cfg_usable_blocks;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            count_r <= in_count;
            if (op_t'(in_op) == OP_ALLOC) begin
              if (alloc_ok) begin
                state_r <= S_SCAN;
              end else begin
                out_valid_r  <= 1'b1;
                out_index_r  <= '0;
                out_status_r <= ST_NOSPACE;
              end
            end else if (in_count == '0) begin
              out_valid_r  <= 1'b1;
              out_index_r  <= '0;
              out_status_r <= ST_OK;
            end else if (free_range_bad) begin
              out_valid_r  <= 1'b1;
              out_index_r  <= '0;
              out_status_r <= ST_RANGE;
            end else begin
              wr_lo_r  <= EXT_W'(in_start_index);
              wr_hi_r  <= EXT_W'(in_start_index) + EXT_W'(in_count);
              wr_val_r <= 1'b0;
              state_r  <= S_MARK;
            end
          end
        end
        S_SCAN: begin
          // token leaves the last cell
          if (tok[CELLS].valid) begin
            if (tok[CELLS].found) begin
              wr_lo_r  <= EXT_W'(idx_c[CELLS]);
              wr_hi_r  <= EXT_W'(idx_c[CELLS]) + EXT_W'(count_r);
              wr_val_r <= 1'b1;
              state_r  <= S_MARK;
            end else begin
              out_valid_r  <= 1'b1;
              out_index_r  <= '0;
              out_status_r <= ST_NOSPACE;
              state_r      <= S_IDLE;
            end
          end
        end
        S_MARK: begin
          out_valid_r  <= 1'b1;
          out_index_r  <= wr_val_r ? OUT_IDX_W'(wr_lo_r) : '0;
          out_status_r <= ST_OK;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_status = out_status_r;

endmodule

### rtl/core/bmra_checker.sv
`include "bitmap_run_block_allocator_unit_macros.svh"

module bmra_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [bmra_pkg::OP_W-1:0]     in_op,
  input logic [bmra_pkg::CNT_W-1:0]    in_count,
  input logic                          out_valid,
  input logic [bmra_pkg::OUT_IDX_W-1:0] out_index,
  input bmra_pkg::status_t             out_status
);
  import bmra_pkg::*;

  // zero-length allocate is refused on the next cycle
  `BRBA_ASSERT_NEXT(a_alloc_zero, start && !busy && (in_op == OP_ALLOC) && (in_count == '0), out_valid && (out_status == ST_NOSPACE))

  // zero-length free succeeds on the next cycle
  `BRBA_ASSERT_NEXT(a_free_zero, start && !busy && (in_op == OP_FREE) && (in_count == '0), out_valid && (out_status == ST_OK))

  // failed items report index 0
  `BRBA_ASSERT_SAME(a_fail_index, out_valid && (out_status != ST_OK), out_index == '0)

  // an accepted item either keeps the block busy or answers at once
  `BRBA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid)

endmodule

bind bitmap_run_block_allocator_unit bmra_checker u_bmra_checker (.*);
